[design/mfmp_pkg.sv]
`default_nettype none
package mfmp_pkg;
  localparam int unsigned ResW = 30;
  localparam logic [29:0] Prime = 30'd1000000007;
  localparam logic [29:0] PrimeMinus1 = 30'd1000000006;
endpackage
`default_nettype wire

[design/modular_fibonacci_matrix_power.sv]
`default_nettype none
// Channel | Direction | Fields
// in      | input     | exponent[31:0] (in_valid / in_ready)
// out     | output    | fib_prev, fib_cur, fib_next [29:0] (out_valid / out_ready)
//
// A single 30x30 multiplier is shared by every product. Each entry of the result
// matrix costs two products, each followed by an accumulate step. The sum is then
// reduced by folding the bits above 2^30 back in until none are left, then by one
// conditional subtract of P, and the result is latched. A store step follows.
// An item runs EXP_BITS squarings plus one multiply by Q for each set bit, and
// then passes through the done state.
// Reset clears only the sequencer and the output valid flag.
// While an item is being worked on, in_ready is low. A finished result waits in
// the done state until the output register is free, so no result is lost, and a
// new item may be accepted while the previous result still waits to be taken.
module modular_fibonacci_matrix_power #(
  parameter int unsigned EXP_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] exponent,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [29:0]      fib_prev,
  output logic [29:0]      fib_cur,
  output logic [29:0]      fib_next
);
  localparam int unsigned BitW = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;
  // The exponent register spans every bit position that is scanned; bits above
  // the 32 input bits stay zero.
  localparam int unsigned NW = (EXP_BITS > 32) ? EXP_BITS : 32;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_ACC, S_RED, S_STORE, S_DONE
  } state_t;

  state_t state;
  logic [NW-1:0] n;
  logic [BitW-1:0] bitpos;
  logic        mulq;   // current pass multiplies by Q instead of squaring
  logic [1:0]  entry;  // which matrix entry is being formed
  logic        term;   // first or second product of the entry
  logic [29:0] a, b, c, d;
  logic [29:0] na, nb, nc;
  logic [29:0] opx, opy;
  logic [59:0] prod;
  logic [60:0] sum;
  logic [60:0] red;
  logic [29:0] resv;

  // Operands. For acc*acc and acc*Q, with entry (i,j): l(i,0)*r(0,j) + l(i,1)*r(1,j).
  logic [29:0] l0, l1, r0, r1;
  always_comb begin
    l0 = entry[1] ? c : a;
    l1 = entry[1] ? d : b;
    if (mulq) begin
      r0 = 30'd1;
      r1 = entry[0] ? 30'd0 : 30'd1;
    end else begin
      r0 = entry[0] ? b : a;
      r1 = entry[0] ? d : c;
    end
    opx = term ? l1 : l0;
    opy = term ? r1 : r0;
  end

  // Reduction of the 61-bit sum: subtract floor(sum / 2^30) * P approximately,
  // via folding 2^30 mod P = 73741817, then a final compare-subtract loop.
  localparam logic [26:0] Fold = 27'd73741817;
  logic [30:0] hi;
  logic [57:0] foldp;
  assign hi = red[60:30];
  assign foldp = 58'(hi) * 58'(Fold);

  logic last_bit;
  assign last_bit = (bitpos == '0);

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            n <= NW'((EXP_BITS >= 32) ? exponent
                                      : (exponent & ((32'd1 << EXP_BITS) - 32'd1)));
            a <= 30'd1; b <= 30'd0; c <= 30'd0; d <= 30'd1;
            bitpos <= BitW'(EXP_BITS - 1);
            mulq <= 1'b0; entry <= 2'd0; term <= 1'b0; sum <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod <= 60'(opx) * 60'(opy);
          state <= S_ACC;
        end
        S_ACC: begin
          sum <= sum + 61'(prod);
          if (term) begin
            red <= sum + 61'(prod);
            state <= S_RED;
          end else begin
            term <= 1'b1;
            state <= S_MUL;
          end
        end
        S_RED: begin
          // Fold repeatedly until the value fits below 2^30, then correct.
          if (hi != '0) begin
            red <= 61'(red[29:0]) + 61'(foldp);
          end else if (red[29:0] >= mfmp_pkg::Prime) begin
            red <= 61'(red[29:0] - mfmp_pkg::Prime);
          end else begin
            resv <= red[29:0];
            state <= S_STORE;
          end
        end
        S_STORE: begin
          unique case (entry)
            2'd0: na <= resv;
            2'd1: nb <= resv;
            2'd2: nc <= resv;
            default: ;
          endcase
          sum <= '0; term <= 1'b0;
          if (entry != 2'd3) begin
            entry <= entry + 2'd1;
            state <= S_MUL;
          end else begin
            entry <= 2'd0;
            a <= na; b <= nb; c <= nc; d <= resv;
            if (!mulq && n[bitpos]) begin
              mulq <= 1'b1;
              state <= S_MUL;
            end else if (last_bit) begin
              state <= S_DONE;
            end else begin
              mulq <= 1'b0;
              bitpos <= bitpos - BitW'(1);
              state <= S_MUL;
            end
          end
        end
        S_DONE: begin
          // Hand the result over only once the output register is free.
          if (!out_valid || out_ready) begin
            if (n == '0) begin
              fib_prev <= mfmp_pkg::PrimeMinus1; fib_cur <= 30'd0; fib_next <= 30'd1;
            end else begin
              fib_prev <= d; fib_cur <= b; fib_next <= a;
            end
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[test/tb_modular_fibonacci_matrix_power.sv]
`default_nettype none
module tb_modular_fibonacci_matrix_power;

  // The timeout budget is generous: it covers the longest item plus the random
  // idle gaps that the sender and receiver add.
  localparam int unsigned StallLimit = 40000;
  localparam int unsigned NumRandom = 1280;
  localparam logic [63:0] FibMod = 64'd1000000007;

  typedef struct packed {
    logic [29:0] prev;
    logic [29:0] cur;
    logic [29:0] next;
  } fib_triple_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] exponent;
  logic        out_valid;
  logic        out_ready;
  logic [29:0] fib_prev;
  logic [29:0] fib_cur;
  logic [29:0] fib_next;

  modular_fibonacci_matrix_power dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .exponent(exponent),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .fib_prev(fib_prev),
    .fib_cur(fib_cur),
    .fib_next(fib_next)
  );

  logic [31:0] pending_exponents[$];
  fib_triple_t expected_terms[$];
  int unsigned mismatch_count;
  int unsigned idle_cycles;
  int unsigned send_wait;
  int unsigned take_wait;
  bit          stimulus_loaded;
  bit          done;

  // Both matrices are symmetric 2x2 as [[a, b], [b, d]] in Fibonacci form,
  // but the general product is kept so the math reads plainly.
  function automatic logic [63:0] pair_mod(input logic [63:0] x1, input logic [63:0] y1,
                                           input logic [63:0] x2, input logic [63:0] y2);
    pair_mod = (x1 * y1 + x2 * y2) % FibMod;
  endfunction

  // Square-and-multiply from the top bit down; Q^n holds F(n+1), F(n), F(n-1).
  function automatic fib_triple_t fib_terms(input logic [31:0] n);
    logic [63:0] a, b, c, d, ta, tb, tc, td;
    fib_triple_t r;
    a = 64'd1; b = 64'd0; c = 64'd0; d = 64'd1;
    if (n == 0) begin
      r.prev = mfmp_pkg::PrimeMinus1;
      r.cur = 30'd0;
      r.next = 30'd1;
      return r;
    end
    for (int i = 31; i >= 0; i--) begin
      ta = pair_mod(a, a, b, c);
      tb = pair_mod(a, b, b, d);
      tc = pair_mod(c, a, d, c);
      td = pair_mod(c, b, d, d);
      a = ta; b = tb; c = tc; d = td;
      if (n[i]) begin
        ta = (a + b) % FibMod;
        tb = a;
        tc = (c + d) % FibMod;
        td = c;
        a = ta; b = tb; c = tc; d = td;
      end
    end
    r.prev = d[29:0];
    r.cur = b[29:0];
    r.next = a[29:0];
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    logic [31:0] directed[$];
    logic [31:0] v;
    rst = 1'b1;
    stimulus_loaded = 1'b0;
    directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd10, 32'd45, 32'd46, 32'd100,
                 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555,
                 32'hAAAA_AAAA, 32'h0000_FFFF, 32'hFFFF_0000, 32'd1000000007,
                 32'd1000000006, 32'd2000000016};
    foreach (directed[k]) pending_exponents = {pending_exponents, directed[k]};
    // Small indices are checked against easy-to-spot values, large ones cover
    // every bit and the long squaring chains.
    for (int k = 0; k < NumRandom; k++) begin
      case ($urandom_range(0, 3))
        0: v = $urandom_range(0, 200);
        1: v = $urandom & ((32'd1 << $urandom_range(1, 31)) - 1);
        default: v = $urandom;
      endcase
      pending_exponents = {pending_exponents, v};
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    stimulus_loaded = 1'b1;
  end

  // Driver: holds each item until accepted, then waits a random gap.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      exponent <= '0;
      send_wait <= $urandom_range(0, 4);
    end else if (in_valid && in_ready) begin
      expected_terms = {expected_terms, fib_terms(exponent)};
      in_valid <= 1'b0;
      send_wait <= $urandom_range(0, 4);
    end else if (!in_valid && stimulus_loaded && pending_exponents.size() != 0) begin
      if (send_wait == 0) begin
        in_valid <= 1'b1;
        exponent <= pending_exponents.pop_front();
      end else begin
        send_wait <= send_wait - 1;
      end
    end
  end

  // Monitor: raises ready after a random stall and checks each result item.
  always @(posedge clk) begin
    fib_triple_t want;
    if (rst) begin
      mismatch_count = 0;
      out_ready <= 1'b0;
      take_wait <= $urandom_range(0, 4);
    end else if (out_valid && out_ready) begin
      if (expected_terms.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result item: %0d %0d %0d", fib_prev, fib_cur, fib_next);
      end else begin
        want = expected_terms.pop_front();
        if (fib_prev !== want.prev || fib_cur !== want.cur || fib_next !== want.next) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                     want.prev, want.cur, want.next, fib_prev, fib_cur, fib_next);
        end
      end
      out_ready <= 1'b0;
      take_wait <= $urandom_range(0, 4);
    end else if (!out_ready) begin
      if (take_wait == 0) out_ready <= 1'b1;
      else take_wait <= take_wait - 1;
    end
  end

  // Watchdog and end of run.
  initial begin
    idle_cycles = 0;
    done = 1'b0;
    while (!done) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (stimulus_loaded && pending_exponents.size() == 0 && !in_valid
          && expected_terms.size() == 0) begin
        // Let any stray result item show up before deciding.
        repeat (400) @(posedge clk);
        done = 1'b1;
      end else if (idle_cycles >= StallLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
    if (mismatch_count == 0 && expected_terms.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

[sim.f]
design/mfmp_pkg.sv
design/modular_fibonacci_matrix_power.sv
test/tb_modular_fibonacci_matrix_power.sv
